// ----- hdl/sms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample statistics package
// Request and result types and shared constants for the sample mean,
// deviation and standard error block.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int TOTAL_W         = 11;
  localparam int RES_W           = 16;
  localparam int MAX_SAMPLES_DEF = 1024;

  // One incoming sample.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  // One result per set.
  typedef struct packed {
    logic [TOTAL_W-1:0]         sample_total;
    logic signed [RES_W-1:0]    mean;
    logic [RES_W-1:0]           std_dev;
    logic [RES_W-1:0]           std_err;
    logic                       too_few;
    logic                       overflow;
  } out_t;

endpackage
`default_nettype wire

// ----- hdl/sample_mean_stddev_stderr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample mean, standard deviation and standard error
// Accumulates signed Q8.8 samples and reports count, mean, sample standard
// deviation and standard error for each set ended by a last flag.
// ----------------------------------------------------------------------------
// Samples are taken one per clock while full is low. Each set's sums go
// into a two-entry queue, so accumulation of the next set continues while
// an engine computes the statistics of the previous one. The engine works
// with a shift-add multiplier, a restoring divider and a square root unit.
// full rises only while two finished sets wait in the queue.
module sample_mean_stddev_stderr #(
  parameter int MAX_SAMPLES = sms_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire sms_pkg::in_t  request,
  output logic               empty,
  input  wire logic          pop,
  output sms_pkg::out_t      result
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SW = 17 + $clog2(MAX_SAMPLES);
  localparam int QW = 31 + $clog2(MAX_SAMPLES);
  localparam int JW = 1 + CW + SW + QW;

  logic          q_wr, q_rd, q_valid, q_full;
  logic [JW-1:0] q_wdata, q_rdata;

  assign full = q_full;

  // Accumulator front end.
  sms_front #(
    .MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .SW(SW), .QW(QW), .JW(JW)
  ) u_front (
    .clk(clk), .rst(rst), .push(push), .request(request),
    .q_full(q_full), .q_wr(q_wr), .q_data(q_wdata)
  );

  // Queue of finished sets.
  sms_queue #(.W(JW)) u_queue (
    .clk(clk), .rst(rst), .wr(q_wr), .wdata(q_wdata),
    .rd(q_rd), .valid(q_valid), .full(q_full), .rdata(q_rdata)
  );

  // Statistics engine.
  sms_back #(
    .MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .SW(SW), .QW(QW), .JW(JW)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_rdata), .q_rd(q_rd),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule
`default_nettype wire

// ----- hdl/sms_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Set queue
// Two-entry queue of finished accumulator sets between front and back.
// ----------------------------------------------------------------------------
module sms_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  input  wire logic         rd,
  output logic              valid,
  output logic              full,
  output logic [W-1:0]      rdata
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign rdata = mem[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      if ((wr && !full) && !(rd && valid)) begin
        count <= count + 2'd1;
      end else if (!(wr && !full) && (rd && valid)) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sms_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample accumulator
// Adds each sample, up to MAX_SAMPLES per set, to the count, sum and sum of
// squares, and hands the finished set to the queue on the last sample.
// ----------------------------------------------------------------------------
module sms_front #(
  parameter int MAX_SAMPLES = sms_pkg::MAX_SAMPLES_DEF,
  parameter int CW = $clog2(MAX_SAMPLES + 1),
  parameter int SW = 17 + $clog2(MAX_SAMPLES),
  parameter int QW = 31 + $clog2(MAX_SAMPLES),
  parameter int JW = 1 + CW + SW + QW
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire sms_pkg::in_t   request,
  input  wire logic           q_full,
  output logic                q_wr,
  output logic [JW-1:0]       q_data
);

  logic [CW-1:0]        count, count_next;
  logic signed [SW-1:0] sum, sum_next;
  logic [QW-1:0]        sumsq, sumsq_next;
  logic                 dropped, dropped_next;
  logic signed [31:0]   square;
  logic                 accept;

  assign accept = push && !q_full;
  assign square = request.sample * request.sample;

  // Accumulate unless the set is already at capacity.
  always_comb begin
    count_next   = count;
    sum_next     = sum;
    sumsq_next   = sumsq;
    dropped_next = dropped;
    if (count < CW'(MAX_SAMPLES)) begin
      count_next = count + CW'(1);
      sum_next   = sum + SW'(request.sample);
      sumsq_next = sumsq + QW'(square[30:0]);
    end else begin
      dropped_next = 1'b1;
    end
  end

  assign q_wr   = accept && request.last;
  assign q_data = {dropped_next, count_next, sum_next, sumsq_next};

  // Running state, cleared after the last sample of a set.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      sumsq   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (request.last) begin
        count   <= '0;
        sum     <= '0;
        sumsq   <= '0;
        dropped <= 1'b0;
      end else begin
        count   <= count_next;
        sum     <= sum_next;
        sumsq   <= sumsq_next;
        dropped <= dropped_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sms_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Statistics engine
// Turns one accumulated set into mean, deviation and standard error with a
// shift-add multiplier, a restoring divider and a digit-by-digit root.
// ----------------------------------------------------------------------------
module sms_back #(
  parameter int MAX_SAMPLES = sms_pkg::MAX_SAMPLES_DEF,
  parameter int CW = $clog2(MAX_SAMPLES + 1),
  parameter int SW = 17 + $clog2(MAX_SAMPLES),
  parameter int QW = 31 + $clog2(MAX_SAMPLES),
  parameter int JW = 1 + CW + SW + QW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire logic [JW-1:0] q_data,
  output logic               q_rd,
  output logic               empty,
  input  wire logic          pop,
  output sms_pkg::out_t      result
);

  localparam int NW  = CW + QW;
  localparam int EW  = 3 * CW;
  localparam int DW  = NW + 2;
  localparam int SQW = DW + (DW % 2);
  localparam int HW  = SQW / 2;
  localparam int KW  = $clog2(SQW + 1);
  localparam int MW  = SW - 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL_NQ  = 4'd1;
  localparam logic [3:0] S_MUL_SS  = 4'd2;
  localparam logic [3:0] S_DIV_MN  = 4'd3;
  localparam logic [3:0] S_MUL_D1  = 4'd4;
  localparam logic [3:0] S_MUL_D2  = 4'd5;
  localparam logic [3:0] S_DIV_SD  = 4'd6;
  localparam logic [3:0] S_SQRT_SD = 4'd7;
  localparam logic [3:0] S_DIV_SE  = 4'd8;
  localparam logic [3:0] S_SQRT_SE = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]           state;
  logic [CW-1:0]        n;
  logic                 neg;
  logic [MW-1:0]        mag;
  logic                 dropped;
  logic [NW-1:0]        num;
  logic [EW-1:0]        den;
  logic [NW-1:0]        ma, mp, mp_add;
  logic [MW-1:0]        mb;
  logic [DW-1:0]        dq;
  logic [EW-1:0]        rem, dvs;
  logic [EW:0]          rem_sh, rem_diff;
  logic                 div_ge;
  logic [SQW-1:0]       sv;
  logic [HW:0]          srem;
  logic [HW+2:0]        srem_sh, trial, srem_diff;
  logic                 sq_ge;
  logic [HW-1:0]        root;
  logic [KW-1:0]        cnt;
  logic [HW:0]          rounded;
  logic [15:0]          root_sat;
  logic signed [15:0]   mean;
  logic [15:0]          sd, se;
  logic                 res_valid;
  sms_pkg::out_t        res;

  // Job fields from the queue head.
  logic                 j_drop;
  logic [CW-1:0]        j_n;
  logic signed [SW-1:0] j_sum;
  logic [QW-1:0]        j_sumsq;
  logic [SW-1:0]        j_abs;

  assign {j_drop, j_n, j_sum, j_sumsq} = q_data;
  assign j_abs = j_sum[SW-1] ? SW'(-j_sum) : SW'(j_sum);
  assign q_rd  = (state == S_IDLE) && q_valid;

  // Shift-add multiplier step.
  assign mp_add = mb[0] ? mp + ma : mp;

  // Restoring divider step.
  assign rem_sh   = {rem, dq[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign div_ge   = (rem_sh >= {1'b0, dvs});

  // Root step, two operand bits at a time.
  assign srem_sh   = {srem, sv[SQW-1:SQW-2]};
  assign trial     = {1'b0, root, 2'b01};
  assign srem_diff = srem_sh - trial;
  assign sq_ge     = (srem_sh >= trial);

  // Round the doubled-resolution root to nearest and saturate.
  assign rounded  = {1'b0, root} + (HW+1)'(1);
  assign root_sat = (rounded[HW:1] > HW'(16'hFFFF)) ? 16'hFFFF : rounded[16:1];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            n       <= j_n;
            neg     <= j_sum[SW-1];
            mag     <= j_abs[MW-1:0];
            dropped <= j_drop;
            ma      <= NW'(j_sumsq);
            mb      <= MW'(j_n);
            mp      <= '0;
            state   <= S_MUL_NQ;
          end
        end
        S_MUL_NQ: begin
          if (mb == '0) begin
            num   <= mp;
            ma    <= NW'(mag);
            mb    <= mag;
            mp    <= '0;
            state <= S_MUL_SS;
          end else begin
            mp <= mp_add;
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        S_MUL_SS: begin
          if (mb == '0) begin
            num   <= num - mp;
            dq    <= DW'(mag + MW'(n >> 1));
            dvs   <= EW'(n);
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV_MN;
          end else begin
            mp <= mp_add;
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        S_DIV_MN: begin
          if (cnt == KW'(DW)) begin
            if (n == '0) begin
              mean <= '0;
            end else if (neg) begin
              mean <= -$signed(dq[15:0]);
            end else begin
              mean <= $signed(dq[15:0]);
            end
            if (n < CW'(2)) begin
              sd    <= '0;
              se    <= '0;
              state <= S_DONE;
            end else begin
              ma    <= NW'(n);
              mb    <= MW'(n - CW'(1));
              mp    <= '0;
              state <= S_MUL_D1;
            end
          end else begin
            rem <= div_ge ? rem_diff[EW-1:0] : rem_sh[EW-1:0];
            dq  <= {dq[DW-2:0], div_ge};
            cnt <= cnt + KW'(1);
          end
        end
        S_MUL_D1: begin
          if (mb == '0) begin
            den   <= mp[EW-1:0];
            ma    <= mp;
            mb    <= MW'(n);
            mp    <= '0;
            state <= S_MUL_D2;
          end else begin
            mp <= mp_add;
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        S_MUL_D2: begin
          if (mb == '0) begin
            dq    <= {num, 2'b00};
            dvs   <= den;
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV_SD;
          end else begin
            mp <= mp_add;
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        S_DIV_SD, S_DIV_SE: begin
          if (cnt == KW'(DW)) begin
            sv    <= SQW'(dq);
            srem  <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= (state == S_DIV_SD) ? S_SQRT_SD : S_SQRT_SE;
          end else begin
            rem <= div_ge ? rem_diff[EW-1:0] : rem_sh[EW-1:0];
            dq  <= {dq[DW-2:0], div_ge};
            cnt <= cnt + KW'(1);
          end
        end
        S_SQRT_SD: begin
          if (cnt == KW'(HW)) begin
            sd    <= root_sat;
            dq    <= {num, 2'b00};
            dvs   <= mp[EW-1:0];
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV_SE;
          end else begin
            srem <= sq_ge ? srem_diff[HW:0] : srem_sh[HW:0];
            root <= {root[HW-2:0], sq_ge};
            sv   <= sv << 2;
            cnt  <= cnt + KW'(1);
          end
        end
        S_SQRT_SE: begin
          if (cnt == KW'(HW)) begin
            se    <= root_sat;
            state <= S_DONE;
          end else begin
            srem <= sq_ge ? srem_diff[HW:0] : srem_sh[HW:0];
            root <= {root[HW-2:0], sq_ge};
            sv   <= sv << 2;
            cnt  <= cnt + KW'(1);
          end
        end
        S_DONE: begin
          if (!res_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || pop)) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || pop)) begin
      res.sample_total <= sms_pkg::TOTAL_W'(n);
      res.mean         <= mean;
      res.std_dev      <= sd;
      res.std_err      <= se;
      res.too_few      <= (n < CW'(2));
      res.overflow     <= dropped;
    end
  end

  assign empty  = !res_valid;
  assign result = res;

  // A waiting result stays until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !pop |=> res_valid)
    else $error("result dropped before pop");

  // Short sets never report a spread.
  a_few: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.too_few |-> (res.std_dev == '0) && (res.std_err == '0))
    else $error("spread reported for a short set");

  // A job is only taken from the queue when the engine is idle.
  a_take: assert property (@(posedge clk) disable iff (rst)
    q_rd |=> (state == S_MUL_NQ))
    else $error("queue read outside idle");

  // Step counter stays within the longest operation.
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_MN || state == S_DIV_SD || state == S_DIV_SE) |-> cnt <= KW'(DW))
    else $error("divider step count out of range");

endmodule
`default_nettype wire

// ----- sim/sample_mean_stddev_stderr_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample statistics testbench
// Feeds sets of Q8.8 samples through the push side under several idle and
// stall patterns, predicts count, mean, deviation and standard error with
// exact integer arithmetic, and checks each popped result in order.
// ----------------------------------------------------------------------------
module sample_mean_stddev_stderr_tb;

  localparam int CAP        = sms_pkg::MAX_SAMPLES_DEF;
  localparam int IDLE_LIMIT = 20000;

  logic          clk;
  logic          rst;
  logic          push;
  logic          full;
  sms_pkg::in_t  request;
  logic          empty;
  logic          pop;
  sms_pkg::out_t result;

  sample_mean_stddev_stderr dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result)
  );

  // Pending requests and expected set statistics.
  sms_pkg::in_t  pending_q[$];
  sms_pkg::out_t stats_q[$];

  // Predictor state for the set in progress.
  int unsigned acc_count;
  longint      acc_sum;
  longint unsigned acc_sumsq;
  bit          acc_dropped;

  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  int unsigned error_count;
  int unsigned requests_done;
  int unsigned sets_done;
  int unsigned idle_cycles;

  // Handshake status captured at the rising edge for the driver.
  logic full_at_edge;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Nearest-rounded sqrt(num/den) in Q8.8, saturated.
  function automatic logic [sms_pkg::RES_W-1:0] sqrt_ratio(longint unsigned num,
                                                          longint unsigned den);
    longint unsigned quad;
    longint unsigned s;
    quad = 4 * (num / den) + (4 * (num % den)) / den;
    s = (int_sqrt(quad) + 1) >> 1;
    if (s > 65535) s = 65535;
    return s[sms_pkg::RES_W-1:0];
  endfunction

  // Folds one accepted sample into the set; closes the set on last.
  task automatic accumulate_sample(sms_pkg::in_t r);
    sms_pkg::out_t st;
    longint unsigned n;
    longint unsigned mag;
    longint unsigned qm;
    longint unsigned num;
    longint v;
    v = longint'(r.sample);
    if (acc_count < CAP) begin
      acc_count++;
      acc_sum += v;
      acc_sumsq += longint'(v * v);
    end else begin
      acc_dropped = 1'b1;
    end
    if (r.last) begin
      n = acc_count;
      mag = (acc_sum < 0) ? longint'(-acc_sum) : acc_sum;
      st = '0;
      st.sample_total = n[sms_pkg::TOTAL_W-1:0];
      if (n > 0) begin
        qm = (mag + n / 2) / n;
        st.mean = (acc_sum < 0) ? -qm[sms_pkg::RES_W-1:0] : qm[sms_pkg::RES_W-1:0];
      end
      st.too_few = (n < 2);
      if (n >= 2) begin
        num = n * acc_sumsq - mag * mag;
        st.std_dev = sqrt_ratio(num, n * (n - 1));
        st.std_err = sqrt_ratio(num, n * (n - 1) * n);
      end
      st.overflow = acc_dropped;
      stats_q.push_back(st);
      acc_count = 0;
      acc_sum = 0;
      acc_sumsq = 0;
      acc_dropped = 1'b0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH set %0d %s: got %0d expected %0d", sets_done, what, got, want);
  endtask

  function automatic logic signed [sms_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'(16'h7fff - 16'($urandom_range(0, 3)));
      1: return 16'(16'h8000 + 16'($urandom_range(0, 3)));
      2: return 16'(16'($urandom_range(0, 255)) - 16'd128);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_set(int unsigned len);
    sms_pkg::in_t r;
    for (int unsigned i = 0; i < len; i++) begin
      r.sample = rand_sample();
      r.last = (i == len - 1);
      pending_q.push_back(r);
    end
  endtask

  task automatic add_const_set(int unsigned len,
                               logic signed [sms_pkg::SAMPLE_W-1:0] v);
    sms_pkg::in_t r;
    for (int unsigned i = 0; i < len; i++) begin
      r.sample = v;
      r.last = (i == len - 1);
      pending_q.push_back(r);
    end
  endtask

  // Driver: presents queued requests, changing inputs at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full_at_edge) begin
        void'(pending_q.pop_front());
      end
      if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        push <= 1'b1;
        request <= pending_q[0];
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end
  end

  // Monitor: samples accepted requests and results at the rising edge.
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    full_at_edge <= rst ? 1'b1 : full;
    if (!rst) begin
      if (push && !full) begin
        accumulate_sample(request);
        requests_done <= requests_done + 1;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (stats_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          sms_pkg::out_t w;
          w = stats_q.pop_front();
          if (result.sample_total != w.sample_total)
            report_mismatch("sample_total", result.sample_total, w.sample_total);
          if (result.mean != w.mean) report_mismatch("mean", result.mean, w.mean);
          if (result.std_dev != w.std_dev)
            report_mismatch("std_dev", result.std_dev, w.std_dev);
          if (result.std_err != w.std_err)
            report_mismatch("std_err", result.std_err, w.std_err);
          if (result.too_few != w.too_few)
            report_mismatch("too_few", result.too_few, w.too_few);
          if (result.overflow != w.overflow)
            report_mismatch("overflow", result.overflow, w.overflow);
        end
        sets_done <= sets_done + 1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("sample_mean_stddev_stderr_tb: done, errors");
      $finish;
    end
  end

  // Stimulus: directed sets, then random sets under each idle pattern.
  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    request = '0;
    full_at_edge = 1'b1;
    acc_count = 0;
    acc_sum = 0;
    acc_sumsq = 0;
    acc_dropped = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    error_count = 0;
    requests_done = 0;
    sets_done = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Single-sample sets, equal samples, and the field extremes.
    add_const_set(1, 16'sh7fff);
    add_const_set(1, 16'sh8000);
    add_const_set(2, 16'sh8000);
    add_const_set(3, 16'sh7fff);
    add_const_set(2, 16'sh0000);
    begin
      sms_pkg::in_t r;
      r.sample = 16'sh8000; r.last = 1'b0; pending_q.push_back(r);
      r.sample = 16'sh7fff; r.last = 1'b0; pending_q.push_back(r);
      r.sample = 16'shffff; r.last = 1'b0; pending_q.push_back(r);
      r.sample = 16'sh0001; r.last = 1'b1; pending_q.push_back(r);
      // Ties in mean rounding: sums of +/-1 over two samples.
      r.sample = 16'sh0001; r.last = 1'b0; pending_q.push_back(r);
      r.sample = 16'sh0000; r.last = 1'b1; pending_q.push_back(r);
      r.sample = 16'shffff; r.last = 1'b0; pending_q.push_back(r);
      r.sample = 16'sh0000; r.last = 1'b1; pending_q.push_back(r);
    end
    add_set(4);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 68; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 68; end
        default: begin send_idle_pct = 38; pop_stall_pct = 38; end
      endcase
      // A full-capacity set with dropped samples, once in the first phase.
      if (ph == 0) add_const_set(CAP + 3, 16'sh8000);
      for (int s = 0; s < 8; s++) add_set($urandom_range(1, 5));
      wait (pending_q.size() == 0);
    end
    wait (stats_q.size() == 0 && acc_count == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d samples in %0d sets across four idle and stall patterns",
             requests_done, sets_done);
    if (error_count == 0) begin
      $display("sample_mean_stddev_stderr_tb: done, clean");
    end else begin
      $display("sample_mean_stddev_stderr_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sms_pkg.sv
hdl/sms_queue.sv
hdl/sms_front.sv
hdl/sms_back.sv
hdl/sample_mean_stddev_stderr.sv
sim/sample_mean_stddev_stderr_tb.sv
